>>> rtl/lqft_pkg.sv
// shared types and constants for the link quality filter table
// no dependencies

package lqft_pkg;

  localparam logic [2:0] REQ_FRAME     = 3'd0;
  localparam logic [2:0] REQ_ADD_SHORT = 3'd1;
  localparam logic [2:0] REQ_ADD_LONG  = 3'd2;
  localparam logic [2:0] REQ_DEL_SHORT = 3'd3;
  localparam logic [2:0] REQ_DEL_LONG  = 3'd4;
  localparam logic [2:0] REQ_CLEAR     = 3'd5;

  localparam logic [1:0] MODE_SHORT = 2'd1;
  localparam logic [1:0] MODE_LONG  = 2'd2;

  localparam logic [2:0] CFG_ENABLE      = 3'd0;
  localparam logic [2:0] CFG_LQI_GAIN    = 3'd1;
  localparam logic [2:0] CFG_LQI_OFFSET  = 3'd2;
  localparam logic [2:0] CFG_DBM_GAIN    = 3'd3;
  localparam logic [2:0] CFG_DBM_OFFSET  = 3'd4;

  localparam logic signed [15:0] UNITY_GAIN   = 16'sh0100;
  localparam logic signed [9:0]  SIGNAL_FLOOR = -10'sd94;

  typedef struct packed {
    logic signed [15:0] dbm_offset;
    logic signed [15:0] dbm_gain;
    logic signed [15:0] lqi_offset;
    logic signed [15:0] lqi_gain;
  } gains_t;

  // one classified request handed from the front to the back
  typedef struct packed {
    logic              adjust;
    logic [7:0]        lqi;
    logic signed [7:0] dbm;
    gains_t            gains;
  } job_t;

endpackage

>>> rtl/link_quality_filter_table_top.sv
// Link quality filter table: one result per item, one item per cycle while out_ready is high.
// Each item passes the front lookup stage, registered in the job register, and
// then the back arithmetic stage, registered in the output register; the single-entry
// registers between stages and at the output let each side stall on its own.
// Table updates take effect for the item right after. Depends on lqft_pkg.

module link_quality_filter_table_top import lqft_pkg::*; #(
  parameter int SHORT_ENTRIES = 16,
  parameter int LONG_ENTRIES  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        req_type,
  input  logic [1:0]        addr_mode,
  input  logic [63:0]       address,
  input  logic              alt_valid,
  input  logic [63:0]       alt_address,
  input  logic signed [15:0] entry_lqi_gain,
  input  logic signed [15:0] entry_lqi_offset,
  input  logic signed [15:0] entry_dbm_gain,
  input  logic signed [15:0] entry_dbm_offset,
  input  logic [7:0]        frame_lqi,
  input  logic signed [7:0] frame_dbm,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        lqi_out,
  output logic signed [7:0] dbm_out,
  output logic              drop,
  output logic              status
);

  logic   enabled;
  gains_t defaults, entry;
  logic   job_valid, job_ready, job_status;
  job_t   job;

  assign cfg_ready = 1'b1;
  assign entry = '{dbm_offset: entry_dbm_offset, dbm_gain: entry_dbm_gain,
                   lqi_offset: entry_lqi_offset, lqi_gain: entry_lqi_gain};

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      defaults <= '{dbm_offset: 16'sd0, dbm_gain: UNITY_GAIN,
                    lqi_offset: 16'sd0, lqi_gain: UNITY_GAIN};
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ENABLE:     enabled <= cfg_data[0];
        CFG_LQI_GAIN:   defaults.lqi_gain <= cfg_data;
        CFG_LQI_OFFSET: defaults.lqi_offset <= cfg_data;
        CFG_DBM_GAIN:   defaults.dbm_gain <= cfg_data;
        CFG_DBM_OFFSET: defaults.dbm_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  lqft_front #(.SHORT_ENTRIES(SHORT_ENTRIES), .LONG_ENTRIES(LONG_ENTRIES)) u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .addr_mode, .address,
    .alt_valid, .alt_address, .entry, .frame_lqi, .frame_dbm, .enabled,
    .defaults, .job_valid, .job_ready, .job, .job_status
  );

  lqft_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .job_status,
    .out_valid, .out_ready, .lqi_out, .dbm_out, .drop, .status
  );

endmodule

>>> rtl/lqft_front.sv
// front: table storage, lookup, table updates, gain selection
// depends on lqft_pkg

module lqft_front import lqft_pkg::*; #(
  parameter int SHORT_ENTRIES = 16,
  parameter int LONG_ENTRIES  = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        req_type,
  input  logic [1:0]        addr_mode,
  input  logic [63:0]       address,
  input  logic              alt_valid,
  input  logic [63:0]       alt_address,
  input  gains_t            entry,
  input  logic [7:0]        frame_lqi,
  input  logic signed [7:0] frame_dbm,
  input  logic              enabled,
  input  gains_t            defaults,
  output logic              job_valid,
  input  logic              job_ready,
  output job_t              job,
  output logic              job_status
);

  localparam int SIW = (SHORT_ENTRIES > 1) ? $clog2(SHORT_ENTRIES) : 1;
  localparam int LIW = (LONG_ENTRIES > 1) ? $clog2(LONG_ENTRIES) : 1;

  logic [SHORT_ENTRIES-1:0] short_valid;
  logic [15:0]              short_key   [SHORT_ENTRIES];
  gains_t                   short_gains [SHORT_ENTRIES];
  logic [LONG_ENTRIES-1:0]  long_valid;
  logic [63:0]              long_key    [LONG_ENTRIES];
  gains_t                   long_gains  [LONG_ENTRIES];

  logic [SHORT_ENTRIES-1:0] s_hit_a, s_hit_b;
  logic [LONG_ENTRIES-1:0]  l_hit_a, l_hit_b;
  logic [15:0] skey_a, skey_b;
  logic [63:0] lkey_a, lkey_b;
  logic fire;

  assign in_ready = !job_valid || job_ready;
  assign fire = in_valid && in_ready;

  // primary key is the source address, secondary the resolved alternate
  always_comb begin
    skey_a = (addr_mode == MODE_LONG) ? alt_address[15:0] : address[15:0];
    lkey_a = (addr_mode == MODE_LONG) ? address : alt_address;
    skey_b = address[15:0];
    lkey_b = address;
    for (int i = 0; i < SHORT_ENTRIES; i++) begin
      s_hit_a[i] = short_valid[i] && short_key[i] == skey_a;
      s_hit_b[i] = short_valid[i] && short_key[i] == skey_b;
    end
    for (int i = 0; i < LONG_ENTRIES; i++) begin
      l_hit_a[i] = long_valid[i] && long_key[i] == lkey_a;
      l_hit_b[i] = long_valid[i] && long_key[i] == lkey_b;
    end
  end

  logic s_any, l_any, s_free_any, l_free_any;
  gains_t s_g, l_g;
  logic [SIW-1:0] s_idx, s_free;
  logic [LIW-1:0] l_idx, l_free;

  // lowest index wins
  always_comb begin
    s_any = 1'b0; s_g = '0; s_idx = '0; s_free_any = 1'b0; s_free = '0;
    for (int i = SHORT_ENTRIES-1; i >= 0; i--) begin
      if (s_hit_a[i]) begin
        s_any = 1'b1; s_g = short_gains[i];
      end
      if (s_hit_b[i]) s_idx = i[$bits(s_idx)-1:0];
      if (!short_valid[i]) begin
        s_free_any = 1'b1; s_free = i[$bits(s_free)-1:0];
      end
    end
    l_any = 1'b0; l_g = '0; l_idx = '0; l_free_any = 1'b0; l_free = '0;
    for (int i = LONG_ENTRIES-1; i >= 0; i--) begin
      if (l_hit_a[i]) begin
        l_any = 1'b1; l_g = long_gains[i];
      end
      if (l_hit_b[i]) l_idx = i[$bits(l_idx)-1:0];
      if (!long_valid[i]) begin
        l_free_any = 1'b1; l_free = i[$bits(l_free)-1:0];
      end
    end
  end

  job_t job_next;
  logic status_next;

  always_comb begin
    job_next = '0;
    job_next.lqi = frame_lqi;
    job_next.dbm = frame_dbm;
    job_next.gains = defaults;
    status_next = 1'b0;
    case (req_type)
      REQ_FRAME: begin
        job_next.adjust = enabled && (addr_mode == MODE_SHORT || addr_mode == MODE_LONG);
        if (addr_mode == MODE_SHORT) begin
          if (|s_hit_b) job_next.gains = short_gains[s_idx];
          else if (alt_valid && l_any) job_next.gains = l_g;
        end else begin
          if (|l_hit_b) job_next.gains = long_gains[l_idx];
          else if (alt_valid && s_any) job_next.gains = s_g;
        end
      end
      REQ_ADD_SHORT: begin
        job_next.lqi = '0; job_next.dbm = '0;
        status_next = !(|s_hit_b) && !s_free_any;
      end
      REQ_ADD_LONG: begin
        job_next.lqi = '0; job_next.dbm = '0;
        status_next = !(|l_hit_b) && !l_free_any;
      end
      default: begin
        job_next.lqi = '0; job_next.dbm = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      short_valid <= '0;
      long_valid <= '0;
    end else begin
      if (fire) begin
        job_valid <= 1'b1;
        job <= job_next;
        job_status <= status_next;
        case (req_type)
          REQ_ADD_SHORT: begin
            if (|s_hit_b) begin
              short_gains[s_idx] <= entry;
            end else if (s_free_any) begin
              short_valid[s_free] <= 1'b1;
              short_key[s_free] <= skey_b;
              short_gains[s_free] <= entry;
            end
          end
          REQ_ADD_LONG: begin
            if (|l_hit_b) begin
              long_gains[l_idx] <= entry;
            end else if (l_free_any) begin
              long_valid[l_free] <= 1'b1;
              long_key[l_free] <= lkey_b;
              long_gains[l_free] <= entry;
            end
          end
          REQ_DEL_SHORT: if (|s_hit_b) short_valid[s_idx] <= 1'b0;
          REQ_DEL_LONG: if (|l_hit_b) long_valid[l_idx] <= 1'b0;
          REQ_CLEAR: begin
            short_valid <= '0;
            long_valid <= '0;
          end
          default: ;
        endcase
      end else if (job_ready) begin
        job_valid <= 1'b0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("queued job changed while stalled");
  a_onehot_del: assert property (@(posedge clk) disable iff (rst)
    fire && req_type == REQ_CLEAR |=> short_valid == '0 && long_valid == '0)
    else $error("clear left valid entries");
  a_full: assert property (@(posedge clk) disable iff (rst)
    fire && req_type == REQ_ADD_SHORT && status_next |-> &short_valid)
    else $error("full status with free slot");

endmodule

>>> rtl/lqft_back.sv
// back: multiply, offset, saturate and drop decision, with output register
// depends on lqft_pkg

module lqft_back import lqft_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  output logic              job_ready,
  input  job_t              job,
  input  logic              job_status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        lqi_out,
  output logic signed [7:0] dbm_out,
  output logic              drop,
  output logic              status
);

  logic signed [25:0] lqi_prod, dbm_prod;
  logic signed [18:0] lqi_sum, dbm_sum;
  logic [7:0] lqi_sat;
  logic signed [7:0] dbm_sat;
  logic drop_next;

  assign job_ready = !out_valid || out_ready;

  always_comb begin
    lqi_prod = $signed({18'd0, job.lqi}) * 26'(job.gains.lqi_gain);
    dbm_prod = 26'(job.dbm - SIGNAL_FLOOR) * 26'(job.gains.dbm_gain);
    // arithmetic shift is the floor
    lqi_sum = 19'(lqi_prod >>> 8) + 19'(job.gains.lqi_offset);
    dbm_sum = 19'(dbm_prod >>> 8) + 19'(job.gains.dbm_offset) + 19'(SIGNAL_FLOOR);
    if (lqi_sum > 19'sd255) lqi_sat = 8'd255;
    else if (lqi_sum < 0) lqi_sat = 8'd0;
    else lqi_sat = lqi_sum[7:0];
    if (dbm_sum > 19'sd127) dbm_sat = 8'sd127;
    else if (dbm_sum < -19'sd128) dbm_sat = -8'sd128;
    else dbm_sat = dbm_sum[7:0];
    drop_next = ((job.gains.dbm_gain != UNITY_GAIN || job.gains.dbm_offset != 0)
                 && dbm_sum < 19'(SIGNAL_FLOOR))
             || ((job.gains.lqi_gain != UNITY_GAIN || job.gains.lqi_offset != 0)
                 && lqi_sat == 8'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (job_valid && job_ready) begin
      out_valid <= 1'b1;
      lqi_out <= job.adjust ? lqi_sat : job.lqi;
      dbm_out <= job.adjust ? dbm_sat : job.dbm;
      drop <= job.adjust && drop_next;
      status <= job_status;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_nodrop: assert property (@(posedge clk) disable iff (rst)
    job_valid && job_ready && !job.adjust |=> !drop)
    else $error("drop on unadjusted frame");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lqi_out) && $stable(drop))
    else $error("result changed while stalled");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !drop)
    else $error("status and drop together");

endmodule
